// File: sv/complex_arith_unit_assert.svh
// ---------------------------------------------------------------------------
// complex_arith_unit assertion macros
// Concurrent check wrappers on clk; CAU_ASSERT is held off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef COMPLEX_ARITH_UNIT_ASSERT_SVH
`define COMPLEX_ARITH_UNIT_ASSERT_SVH

// implication check, disabled in reset
`define CAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that is also live during reset
`define CAU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/cau_pkg.sv
// ---------------------------------------------------------------------------
// cau_pkg
// Types, widths and codes shared by the complex arithmetic unit.
// ---------------------------------------------------------------------------
package cau_pkg;

  localparam int PART_WIDTH = 16;
  localparam int FRAC_BITS  = 8;
  localparam int PW2        = 2 * PART_WIDTH;            // product width
  localparam int QB         = PART_WIDTH + FRAC_BITS + 1; // quotient bits, one per cell
  localparam int RW         = PW2 + QB;                  // remainder width
  localparam logic [RW-1:0] RND =
    (FRAC_BITS > 0) ? (RW'(1) << (FRAC_BITS > 0 ? FRAC_BITS - 1 : 0)) : '0;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } cau_op_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_SAT = 2'd1,
    ST_DZ  = 2'd2
  } cau_status_t;

  typedef struct packed {
    cau_op_t                op;
    logic signed [PART_WIDTH-1:0] a_re;
    logic signed [PART_WIDTH-1:0] a_im;
    logic signed [PART_WIDTH-1:0] b_re;
    logic signed [PART_WIDTH-1:0] b_im;
  } cau_in_t;

  typedef struct packed {
    logic signed [PART_WIDTH-1:0] res_re;
    logic signed [PART_WIDTH-1:0] res_im;
    cau_status_t                  status;
  } cau_out_t;

  // one result part in flight through the divider row
  typedef struct packed {
    logic          neg;
    logic          ovf;
    logic [RW-1:0] rem;
    logic [QB-1:0] q;
  } cau_lane_t;

  typedef struct packed {
    logic          valid;
    cau_op_t       op;
    logic          dz;
    logic [RW-1:0] dsh;
    cau_lane_t     re;
    cau_lane_t     im;
  } cau_cell_t;

endpackage

// File: sv/cau_front.sv
// ---------------------------------------------------------------------------
// cau_front
// Products, sums, divisor and overflow screen ahead of the divider row.
// ---------------------------------------------------------------------------
module cau_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_valid,
  input  cau_pkg::cau_in_t   in_data,
  output cau_pkg::cau_cell_t cell_o
);
  import cau_pkg::*;

  localparam int SW = PW2 + 1;

  typedef struct packed {
    logic                          valid;
    cau_op_t                       op;
    logic signed [PW2-1:0]         p_rr;
    logic signed [PW2-1:0]         p_ii;
    logic signed [PW2-1:0]         p_ri;
    logic signed [PW2-1:0]         p_ir;
    logic signed [PW2-1:0]         p_bb;
    logic signed [PW2-1:0]         p_dd;
    logic signed [PART_WIDTH:0]    s_re;
    logic signed [PART_WIDTH:0]    s_im;
  } stage_a_t;

  stage_a_t  a_r, a_nxt;
  cau_cell_t b_r, b_nxt;

  logic signed [SW-1:0] s_re, s_im, m_re, m_im;
  logic [PW2-1:0]       mag_re, mag_im, den;
  logic [PW2:0]         den_sum;

  always_comb begin
    a_nxt.valid = in_valid;
    a_nxt.op    = in_data.op;
    a_nxt.p_rr  = PW2'(in_data.a_re) * PW2'(in_data.b_re);
    a_nxt.p_ii  = PW2'(in_data.a_im) * PW2'(in_data.b_im);
    a_nxt.p_ri  = PW2'(in_data.a_re) * PW2'(in_data.b_im);
    a_nxt.p_ir  = PW2'(in_data.a_im) * PW2'(in_data.b_re);
    a_nxt.p_bb  = PW2'(in_data.b_re) * PW2'(in_data.b_re);
    a_nxt.p_dd  = PW2'(in_data.b_im) * PW2'(in_data.b_im);
    if (in_data.op == OP_SUB) begin
      a_nxt.s_re = (PART_WIDTH+1)'(in_data.a_re) - (PART_WIDTH+1)'(in_data.b_re);
      a_nxt.s_im = (PART_WIDTH+1)'(in_data.a_im) - (PART_WIDTH+1)'(in_data.b_im);
    end else begin
      a_nxt.s_re = (PART_WIDTH+1)'(in_data.a_re) + (PART_WIDTH+1)'(in_data.b_re);
      a_nxt.s_im = (PART_WIDTH+1)'(in_data.a_im) + (PART_WIDTH+1)'(in_data.b_im);
    end
  end

  always_comb begin
    case (a_r.op)
      OP_MUL: begin
        s_re = SW'(a_r.p_rr) - SW'(a_r.p_ii);
        s_im = SW'(a_r.p_ri) + SW'(a_r.p_ir);
      end
      OP_DIV: begin
        s_re = SW'(a_r.p_rr) + SW'(a_r.p_ii);
        s_im = SW'(a_r.p_ir) - SW'(a_r.p_ri);
      end
      default: begin
        s_re = SW'(a_r.s_re);
        s_im = SW'(a_r.s_im);
      end
    endcase
    m_re    = s_re[SW-1] ? -s_re : s_re;
    m_im    = s_im[SW-1] ? -s_im : s_im;
    mag_re  = m_re[PW2-1:0];
    mag_im  = m_im[PW2-1:0];
    // squares are never negative
    den_sum = {1'b0, $unsigned(a_r.p_bb)} + {1'b0, $unsigned(a_r.p_dd)};
    den     = den_sum[PW2-1:0];

    b_nxt.valid  = a_r.valid;
    b_nxt.op     = a_r.op;
    b_nxt.dz     = (a_r.op == OP_DIV) && (den == '0);
    b_nxt.dsh    = RW'(den) << (QB - 1);
    b_nxt.re.neg = s_re[SW-1];
    b_nxt.im.neg = s_im[SW-1];
    // integer quotient at or above 2^PART_WIDTH saturates regardless
    b_nxt.re.ovf = (3*PART_WIDTH)'(mag_re) >= {den, {PART_WIDTH{1'b0}}};
    b_nxt.im.ovf = (3*PART_WIDTH)'(mag_im) >= {den, {PART_WIDTH{1'b0}}};
    b_nxt.re.q   = '0;
    b_nxt.im.q   = '0;
    if (a_r.op == OP_DIV) begin
      b_nxt.re.rem = RW'({mag_re, {(FRAC_BITS+1){1'b0}}});
      b_nxt.im.rem = RW'({mag_im, {(FRAC_BITS+1){1'b0}}});
    end else begin
      b_nxt.re.rem = RW'(mag_re);
      b_nxt.im.rem = RW'(mag_im);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r.valid <= 1'b0;
      b_r.valid <= 1'b0;
    end else if (adv) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
    end
  end

  assign cell_o = b_r;

endmodule

// File: sv/cau_cell.sv
// ---------------------------------------------------------------------------
// cau_cell
// One restoring-division step for both parts; non-divide items pass through.
// ---------------------------------------------------------------------------
module cau_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  cau_pkg::cau_cell_t cell_i,
  output cau_pkg::cau_cell_t cell_o
);
  import cau_pkg::*;

  cau_cell_t cell_r, cell_nxt;

  always_comb begin
    cell_nxt = cell_i;
    if (cell_i.op == OP_DIV) begin
      if (cell_i.re.rem >= cell_i.dsh) begin
        cell_nxt.re.rem = cell_i.re.rem - cell_i.dsh;
        cell_nxt.re.q   = {cell_i.re.q[QB-2:0], 1'b1};
      end else begin
        cell_nxt.re.q   = {cell_i.re.q[QB-2:0], 1'b0};
      end
      if (cell_i.im.rem >= cell_i.dsh) begin
        cell_nxt.im.rem = cell_i.im.rem - cell_i.dsh;
        cell_nxt.im.q   = {cell_i.im.q[QB-2:0], 1'b1};
      end else begin
        cell_nxt.im.q   = {cell_i.im.q[QB-2:0], 1'b0};
      end
      cell_nxt.dsh = cell_i.dsh >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (adv) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_o = cell_r;

endmodule

// File: sv/complex_arith_unit.sv
// ---------------------------------------------------------------------------
// complex_arith_unit
// Complex add, subtract, multiply and divide on signed fixed-point parts.
// ---------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one op plus two complex operands; a
//   transfer happens on a clock edge with in_valid high and in_stall low.
//   out_valid/out_stall/out_data carry res_re, res_im and status.
// Throughput: one transfer per cycle, every op code, while no stall holds the pipe.
// Pipeline, same for all ops (Q8.8 as configured): two front stages
//   (products, then sums/divisor), one cell per quotient bit in the divider
//   row (PART_WIDTH + FRAC_BITS + 1 cells), and the round/saturate output
//   register.
// Stall: the whole pipe advances as one; while out_valid is high and
//   out_stall is asserted, every stage holds and in_stall is raised.
//   Bubbles are not squeezed out: a stall freezes every stage, empty or not.
// Reset: rst_n low clears all stage valid bits; no result is presented
//   and no state survives (the block keeps none).
// Status: ok, saturated (either part clipped), or divide by zero, in
//   which case both parts read zero.
// ---------------------------------------------------------------------------
module complex_arith_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  cau_pkg::cau_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output cau_pkg::cau_out_t out_data
);
  import cau_pkg::*;

  // global advance: the output register is free or being drained
  logic adv;

  cau_cell_t chain [QB+1];

  cau_out_t out_r, out_nxt;
  logic     out_valid_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  cau_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_valid),
    .in_data  (in_data),
    .cell_o   (chain[0])
  );

  // divider row: cell k settles quotient bit QB-1-k
  for (genvar k = 0; k < QB; k++) begin : g_cell
    cau_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .cell_i (chain[k]),
      .cell_o (chain[k+1])
    );
  end

  // final magnitude per part, before the clip
  function automatic logic [RW-1:0] part_mag(cau_op_t op, cau_lane_t l);
    logic [QB:0] qr;
    qr = ({1'b0, l.q} + (QB+1)'(1)) >> 1;   // extra quotient bit gives half-up rounding
    case (op)
      OP_DIV:  part_mag = l.ovf ? (RW'(1) << PART_WIDTH) : RW'(qr);
      OP_MUL:  part_mag = (l.rem + RND) >> FRAC_BITS;
      default: part_mag = l.rem;
    endcase
  endfunction

  logic [RW-1:0]         mag_re, mag_im, lim_re, lim_im;
  logic [PART_WIDTH-1:0] clip_re, clip_im;
  logic                  sat_re, sat_im;
  cau_cell_t             last;

  always_comb begin
    last    = chain[QB];
    mag_re  = part_mag(last.op, last.re);
    mag_im  = part_mag(last.op, last.im);
    // negative side reaches one step further
    lim_re  = (RW'(1) << (PART_WIDTH - 1)) - RW'(!last.re.neg);
    lim_im  = (RW'(1) << (PART_WIDTH - 1)) - RW'(!last.im.neg);
    sat_re  = mag_re > lim_re;
    sat_im  = mag_im > lim_im;
    clip_re = sat_re ? lim_re[PART_WIDTH-1:0] : mag_re[PART_WIDTH-1:0];
    clip_im = sat_im ? lim_im[PART_WIDTH-1:0] : mag_im[PART_WIDTH-1:0];
    if (last.dz) begin
      out_nxt.res_re = '0;
      out_nxt.res_im = '0;
      out_nxt.status = ST_DZ;
    end else begin
      out_nxt.res_re = last.re.neg ? -$signed(clip_re) : $signed(clip_re);
      out_nxt.res_im = last.im.neg ? -$signed(clip_im) : $signed(clip_im);
      out_nxt.status = (sat_re || sat_im) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= last.valid;
      out_r       <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---- checks ----
`include "complex_arith_unit_assert.svh"

  `CAU_ASSERT(a_dz_zero, (out_valid && out_data.status == ST_DZ) |-> (out_data.res_re == '0 && out_data.res_im == '0), "divide-by-zero result not zero")
  `CAU_ASSERT(a_status_code, out_valid |-> (out_data.status == ST_OK || out_data.status == ST_SAT || out_data.status == ST_DZ), "undefined status code")
  `CAU_ASSERT(a_hold_pipe, in_stall |=> $stable(chain[QB]), "divider row moved while stalled")
  `CAU_ASSERT_ALWAYS(a_stall_rule, in_stall == (out_valid && out_stall), "input stall not tied to output backpressure")

endmodule
